/* rtl/autorange_frequency_readout_macros.svh */
// assertion macros for the autorange frequency readout checker
// no dependencies
`ifndef AUTORANGE_FREQUENCY_READOUT_MACROS_SVH
`define AUTORANGE_FREQUENCY_READOUT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AFR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("afr check failed");

// antecedent implies consequent in the next cycle
`define AFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("afr check failed");

`endif

/* rtl/afr_pkg.sv */
// shared types and constants of the autorange frequency readout
// no dependencies
`default_nettype none

package afr_pkg;

    localparam int unsigned FreqW = 27;
    localparam int unsigned PerW = 32;
    localparam int unsigned BcdW = 32;
    localparam int unsigned DivStages = FreqW;
    localparam int unsigned BcdStages = FreqW;

    localparam logic [FreqW-1:0] FREQ_MAX = 27'd99999999;
    localparam logic [FreqW-1:0] REF_CLK_RESET = 27'd4000000;
    localparam logic [FreqW-1:0] DIRECT_THR_RESET = 27'd100;
    localparam logic [FreqW-1:0] MHZ_THR_RESET = 27'd100;

    // register indexes
    localparam logic [1:0] REG_REF_CLK = 2'd0;
    localparam logic [1:0] REG_DIRECT_THR = 2'd1;
    localparam logic [1:0] REG_MHZ_THR = 2'd2;

    // one stage of the reciprocal divider
    typedef struct packed {
        logic             valid;
        logic             running;
        logic [FreqW-1:0] count;
        logic             use_count;
        logic [PerW-1:0]  den;
        logic [FreqW-1:0] num;
        logic [PerW-1:0]  rem;
        logic [FreqW-1:0] quo;
    } div_t;

    // one stage of the binary to bcd converter
    typedef struct packed {
        logic             valid;
        logic             mhz;
        logic [FreqW-1:0] bin;
        logic [BcdW-1:0]  bcd;
    } bcd_t;

endpackage

`default_nettype wire

/* rtl/afr_div_cell.sv */
// one restoring division cell: produces one quotient bit per request
// depends on afr_pkg
`default_nettype none

module afr_div_cell (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  afr_pkg::div_t    din,
    output afr_pkg::div_t    dout
);
    import afr_pkg::*;

    div_t        dout_reg;
    div_t        dout_next;
    logic [PerW:0] rem_sh;
    logic [PerW:0] den_ext;
    logic          ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        rem_sh = {din.rem, din.num[FreqW-1]};
        den_ext = {1'b0, din.den};
        ge = (rem_sh >= den_ext);
        dout_next = din;
        dout_next.num = {din.num[FreqW-2:0], 1'b0};
        dout_next.rem = ge ? PerW'(rem_sh - den_ext) : rem_sh[PerW-1:0];
        dout_next.quo = {din.quo[FreqW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.valid <= 1'b0;
        end else if (en) begin
            dout_reg.valid <= dout_next.valid;
        end
        if (en) begin
            dout_reg.running <= dout_next.running;
            dout_reg.count <= dout_next.count;
            dout_reg.use_count <= dout_next.use_count;
            dout_reg.den <= dout_next.den;
            dout_reg.num <= dout_next.num;
            dout_reg.rem <= dout_next.rem;
            dout_reg.quo <= dout_next.quo;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

/* rtl/afr_bcd_cell.sv */
// one double dabble cell: shifts one binary bit into the bcd digits
// depends on afr_pkg
`default_nettype none

module afr_bcd_cell (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  afr_pkg::bcd_t    din,
    output afr_pkg::bcd_t    dout
);
    import afr_pkg::*;

    bcd_t            dout_reg;
    bcd_t            dout_next;
    logic [BcdW-1:0] adj;

    // add three to every digit of five or more, then shift
    always_comb begin
        for (int d = 0; d < BcdW / 4; d++) begin
            adj[4*d +: 4] = (din.bcd[4*d +: 4] >= 4'd5) ? din.bcd[4*d +: 4] + 4'd3
                                                         : din.bcd[4*d +: 4];
        end
        dout_next = din;
        dout_next.bcd = {adj[BcdW-2:0], din.bin[FreqW-1]};
        dout_next.bin = {din.bin[FreqW-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.valid <= 1'b0;
        end else if (en) begin
            dout_reg.valid <= dout_next.valid;
        end
        if (en) begin
            dout_reg.mhz <= dout_next.mhz;
            dout_reg.bin <= dout_next.bin;
            dout_reg.bcd <= dout_next.bcd;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

/* rtl/autorange_frequency_readout.sv */
// autorange frequency readout top level: divider chain, bcd chain, digit alignment
// depends on afr_pkg, afr_div_cell, afr_bcd_cell
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    running, direct_count, period_ticks
//  m_        out        m_valid / m_ready    digit_0..7, point_position, unit_mhz
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// one request per cycle while the output is not stalled; the pipeline is 27 divider
// cells, a select stage, 27 double dabble cells and the output register.
// the whole pipeline advances together; a stalled output holds every stage.
// synchronous active-low reset clears all valid bits and reloads registers.
`default_nettype none

module autorange_frequency_readout (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output wire        s_ready,
    input  wire        s_running,
    input  wire [26:0] s_direct_count,
    input  wire [31:0] s_period_ticks,
    output wire        m_valid,
    input  wire        m_ready,
    output wire [3:0]  m_digit_0,
    output wire [3:0]  m_digit_1,
    output wire [3:0]  m_digit_2,
    output wire [3:0]  m_digit_3,
    output wire [3:0]  m_digit_4,
    output wire [3:0]  m_digit_5,
    output wire [3:0]  m_digit_6,
    output wire [3:0]  m_digit_7,
    output wire [2:0]  m_point_position,
    output wire        m_unit_mhz,
    input  wire        cfg_we,
    input  wire [1:0]  cfg_index,
    input  wire [26:0] cfg_wdata
);
    import afr_pkg::*;

    logic [FreqW-1:0] ref_clk_reg;
    logic [FreqW-1:0] direct_thr_reg;
    logic [FreqW-1:0] mhz_thr_reg;

    logic             adv;
    div_t             div_in;
    div_t             div_chain [DivStages+1];
    bcd_t             sel_reg;
    bcd_t             sel_next;
    bcd_t             bcd_chain [BcdStages+1];

    logic             m_valid_reg;
    logic [BcdW-1:0]  shown_reg;
    logic [BcdW-1:0]  shown_next;
    logic [2:0]       point_reg;
    logic [2:0]       point_next;
    logic             mhz_reg;
    logic [3:0]       lz;
    logic [FreqW-1:0] count_sat;
    logic [FreqW-1:0] freq;
    div_t             dlast;
    bcd_t             blast;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clk_reg <= REF_CLK_RESET;
            direct_thr_reg <= DIRECT_THR_RESET;
            mhz_thr_reg <= MHZ_THR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_REF_CLK:    ref_clk_reg <= cfg_wdata;
                REG_DIRECT_THR: direct_thr_reg <= cfg_wdata;
                REG_MHZ_THR:    mhz_thr_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // whole pipeline moves when the output slot is free or being taken
    assign adv = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // request entry: saturate the count and pick the mode
    always_comb begin
        count_sat = (s_direct_count > FREQ_MAX) ? FREQ_MAX : s_direct_count;
        div_in.valid = s_valid;
        div_in.running = s_running;
        div_in.count = count_sat;
        div_in.use_count = (count_sat >= direct_thr_reg);
        div_in.den = s_period_ticks;
        div_in.num = ref_clk_reg;
        div_in.rem = '0;
        div_in.quo = '0;
    end

    assign div_chain[0] = div_in;

    // reciprocal divider chain
    for (genvar i = 0; i < DivStages; i++) begin : g_div
        afr_div_cell u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .din     (div_chain[i]),
            .dout    (div_chain[i+1])
        );
    end

    // frequency select and unit decision
    always_comb begin
        dlast = div_chain[DivStages];
        if (!dlast.running) begin
            freq = '0;
        end else if (dlast.use_count) begin
            freq = dlast.count;
        end else if (dlast.den == '0) begin
            freq = '0;
        end else begin
            freq = (dlast.quo > FREQ_MAX) ? FREQ_MAX : dlast.quo;
        end
        sel_next.valid = dlast.valid;
        sel_next.mhz = (freq >= mhz_thr_reg);
        sel_next.bin = freq;
        sel_next.bcd = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg.valid <= 1'b0;
        end else if (adv) begin
            sel_reg.valid <= sel_next.valid;
        end
        if (adv) begin
            sel_reg.mhz <= sel_next.mhz;
            sel_reg.bin <= sel_next.bin;
            sel_reg.bcd <= sel_next.bcd;
        end
    end

    assign bcd_chain[0] = sel_reg;

    // binary to bcd chain
    for (genvar j = 0; j < BcdStages; j++) begin : g_bcd
        afr_bcd_cell u_bcd (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .din     (bcd_chain[j]),
            .dout    (bcd_chain[j+1])
        );
    end

    // left-align digits and place the decimal point
    always_comb begin
        blast = bcd_chain[BcdStages];
        lz = 4'd8;
        for (int d = 0; d < BcdW / 4; d++) begin
            if (blast.bcd[4*d +: 4] != 4'd0) begin
                lz = 4'(7 - d);
            end
        end
        if (blast.mhz) begin
            point_next = (blast.bcd[BcdW-1 -: 4] != 4'd0) ? 3'd1 : 3'd0;
            shown_next = (point_next == 3'd1) ? blast.bcd : {blast.bcd[BcdW-5:0], 4'd0};
        end else begin
            point_next = (lz == 4'd8) ? 3'd0 : 3'(4'd7 - lz);
            shown_next = blast.bcd << {lz, 2'b00};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= blast.valid;
        end
        if (adv) begin
            shown_reg <= shown_next;
            point_reg <= point_next;
            mhz_reg <= blast.mhz;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_digit_0 = shown_reg[31:28];
    assign m_digit_1 = shown_reg[27:24];
    assign m_digit_2 = shown_reg[23:20];
    assign m_digit_3 = shown_reg[19:16];
    assign m_digit_4 = shown_reg[15:12];
    assign m_digit_5 = shown_reg[11:8];
    assign m_digit_6 = shown_reg[7:4];
    assign m_digit_7 = shown_reg[3:0];
    assign m_point_position = point_reg;
    assign m_unit_mhz = mhz_reg;

endmodule

`default_nettype wire

/* rtl/afr_checker.sv */
// port-level checks of the autorange frequency readout, bound to the top level
// depends on autorange_frequency_readout_macros.svh
`default_nettype none
`include "autorange_frequency_readout_macros.svh"

module afr_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input wire [3:0] m_digit_0,
    input wire [3:0] m_digit_7,
    input wire [2:0] m_point_position,
    input wire       m_unit_mhz
);

    // a stalled request keeps its leading digit and point
    `AFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_digit_0) && $stable(m_point_position))

    // the first and last digits are decimal
    `AFR_ASSERT_SAME(a_dec, aclk, aresetn, m_valid, m_digit_0 <= 4'd9 && m_digit_7 <= 4'd9)

    // hz readout is left aligned, so the padded last digit is zero
    `AFR_ASSERT_SAME(a_pad, aclk, aresetn, m_valid && !m_unit_mhz && m_point_position != 3'd7, m_digit_7 == 4'd0)

    // mhz readout has at most two integer digits
    `AFR_ASSERT_SAME(a_mhz, aclk, aresetn, m_valid && m_unit_mhz, m_point_position == 3'd0 || m_point_position == 3'd1)

endmodule

bind autorange_frequency_readout afr_checker u_afr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_digit_0        (m_digit_0),
    .m_digit_7        (m_digit_7),
    .m_point_position (m_point_position),
    .m_unit_mhz       (m_unit_mhz)
);

`default_nettype wire
